[hw/rtl/rpt_pkg.sv]
package rpt_pkg;

    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_ROUTE_AGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_AGE      = 2'd2;

    localparam logic [15:0] DEST_TIMEOUT_RST  = 16'd600;
    localparam logic [15:0] NEW_ROUTE_AGE_RST = 16'd300;
    localparam logic [23:0] DEAD_AGE_RST      = 24'd86400;

    localparam logic signed [31:0] LOWEST_PREF = 32'sh8000_0000;

    localparam logic OP_ADD       = 1'b0;
    localparam logic OP_ADVERTISE = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [1:0] {
        ST_EXISTING = 2'd0,
        ST_APPENDED = 2'd1,
        ST_REPLACED = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] dest_timeout;
        logic [15:0] new_route_age;
        logic [23:0] dead_age;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        addr;
        logic signed [31:0] pref;
        logic [31:0]        seen;
    } t_entry;

endpackage

[hw/rtl/rpt_mem.sv]
module rpt_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output rpt_pkg::t_entry      o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  rpt_pkg::t_entry      i_wr_data
);
    import rpt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/rpt_ctrl.sv]
module rpt_ctrl #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IDX_W   = 4,
    parameter int unsigned CNT_W   = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpt_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [31:0]          i_gateway_addr,
    input  logic signed [31:0]   i_preference,
    input  logic [31:0]          i_now_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [1:0]           o_status,
    output logic [31:0]          o_entry_addr,
    output logic signed [31:0]   o_entry_pref,
    output logic                 o_pref_taken,
    output logic                 o_last,
    output logic                 o_rd_en,
    output logic [IDX_W-1:0]     o_rd_idx,
    input  rpt_pkg::t_entry      i_rd_data,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_idx,
    output rpt_pkg::t_entry      o_wr_data
);
    import rpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_EVAL   = 5'b00100,
        S_FINISH = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    t_state                 r_state, n_state;
    logic                   r_op, n_op;
    logic [31:0]            r_host, n_host;
    logic signed [31:0]     r_pref, n_pref;
    logic [31:0]            r_now, n_now;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic signed [31:0]     r_found_pref, n_found_pref;
    logic                   r_found_taken, n_found_taken;
    logic                   r_have_old, n_have_old;
    logic [IDX_W-1:0]       r_old_idx, n_old_idx;
    logic [31:0]            r_old_age, n_old_age;
    logic                   r_pend_valid, n_pend_valid;
    logic [31:0]            r_pend_addr, n_pend_addr;
    logic signed [31:0]     r_pend_pref, n_pend_pref;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_kind, n_out_kind;
    logic [1:0]             r_out_status, n_out_status;
    logic [31:0]            r_out_addr, n_out_addr;
    logic signed [31:0]     r_out_pref, n_out_pref;
    logic                   r_out_taken, n_out_taken;
    logic                   r_out_last, n_out_last;

    logic                   out_free;
    logic [31:0]            age;
    logic [CNT_W-1:0]       idx_next;
    logic                   scan_done;
    logic                   live;
    logic                   stale;

    assign out_free  = !r_out_valid || i_out_ready;
    assign age       = r_now - i_rd_data.seen;
    assign idx_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign scan_done = (idx_next == r_count);
    assign live      = (age <= {8'd0, i_cfg.dead_age});
    assign stale     = (age > {16'd0, i_cfg.dest_timeout});

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_host        = r_host;
        n_pref        = r_pref;
        n_now         = r_now;
        n_idx         = r_idx;
        n_count       = r_count;
        n_found       = r_found;
        n_slot        = r_slot;
        n_found_pref  = r_found_pref;
        n_found_taken = r_found_taken;
        n_have_old    = r_have_old;
        n_old_idx     = r_old_idx;
        n_old_age     = r_old_age;
        n_pend_valid  = r_pend_valid;
        n_pend_addr   = r_pend_addr;
        n_pend_pref   = r_pend_pref;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_kind    = r_out_kind;
        n_out_status  = r_out_status;
        n_out_addr    = r_out_addr;
        n_out_pref    = r_out_pref;
        n_out_taken   = r_out_taken;
        n_out_last    = r_out_last;
        o_rd_en       = 1'b0;
        o_rd_idx      = r_idx;
        o_wr_en       = 1'b0;
        o_wr_idx      = r_idx;
        o_wr_data     = '{addr: r_host, pref: r_pref, seen: r_now};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_op;
                    n_host       = i_gateway_addr;
                    n_pref       = i_preference;
                    n_now        = i_now_time;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_have_old   = 1'b0;
                    n_pend_valid = 1'b0;
                    if (r_count != '0) begin
                        n_state = S_READ;
                    end else if (i_op == OP_ADD) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_READ: begin
                o_rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_op == OP_ADD) begin
                    if (i_rd_data.addr == r_host) begin
                        n_found       = 1'b1;
                        n_slot        = r_idx;
                        n_found_pref  = i_rd_data.pref;
                        n_found_taken = (r_pref >= i_rd_data.pref) ||
                                        (age >= {16'd0, i_cfg.new_route_age});
                        n_state       = S_FINISH;
                    end else begin
                        // ties keep the lowest index
                        if (!r_have_old || age > r_old_age) begin
                            n_have_old = 1'b1;
                            n_old_idx  = r_idx;
                            n_old_age  = age;
                        end
                        n_idx   = IDX_W'(idx_next);
                        n_state = scan_done ? S_FINISH : S_READ;
                    end
                end else if (!live) begin
                    n_idx   = IDX_W'(idx_next);
                    n_state = scan_done ? S_FLUSH : S_READ;
                end else if (!r_pend_valid || out_free) begin
                    // one item held back so the final one can carry last
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_ENTRY;
                        n_out_status = ST_EXISTING;
                        n_out_addr   = r_pend_addr;
                        n_out_pref   = r_pend_pref;
                        n_out_taken  = 1'b0;
                        n_out_last   = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_addr  = i_rd_data.addr;
                    n_pend_pref  = stale ? LOWEST_PREF : i_rd_data.pref;
                    if (stale) begin
                        o_wr_en   = 1'b1;
                        o_wr_idx  = r_idx;
                        o_wr_data = '{addr: i_rd_data.addr, pref: LOWEST_PREF,
                                      seen: i_rd_data.seen};
                    end
                    n_idx   = IDX_W'(idx_next);
                    n_state = scan_done ? S_FLUSH : S_READ;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_STATUS;
                    n_out_addr  = r_host;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                    if (r_found) begin
                        n_out_status = ST_EXISTING;
                        n_out_taken  = r_found_taken;
                        n_out_pref   = r_found_taken ? r_pref : r_found_pref;
                        o_wr_en      = r_found_taken;
                        o_wr_idx     = r_slot;
                    end else if (r_count < FULL_COUNT) begin
                        n_out_status = ST_APPENDED;
                        n_out_taken  = 1'b1;
                        n_out_pref   = r_pref;
                        o_wr_en      = 1'b1;
                        o_wr_idx     = IDX_W'(r_count);
                        n_count      = r_count + CNT_W'(1);
                    end else if (r_have_old &&
                                 r_old_age > {16'd0, i_cfg.dest_timeout}) begin
                        n_out_status = ST_REPLACED;
                        n_out_taken  = 1'b1;
                        n_out_pref   = r_pref;
                        o_wr_en      = 1'b1;
                        o_wr_idx     = r_old_idx;
                    end else begin
                        n_out_status = ST_DROPPED;
                        n_out_taken  = 1'b0;
                        n_out_pref   = '0;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_ENTRY;
                    n_out_status = ST_EXISTING;
                    n_out_addr   = r_pend_addr;
                    n_out_pref   = r_pend_pref;
                    n_out_taken  = 1'b0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_host        <= n_host;
        r_pref        <= n_pref;
        r_now         <= n_now;
        r_idx         <= n_idx;
        r_found       <= n_found;
        r_slot        <= n_slot;
        r_found_pref  <= n_found_pref;
        r_found_taken <= n_found_taken;
        r_have_old    <= n_have_old;
        r_old_idx     <= n_old_idx;
        r_old_age     <= n_old_age;
        r_pend_addr   <= n_pend_addr;
        r_pend_pref   <= n_pend_pref;
        r_out_kind    <= n_out_kind;
        r_out_status  <= n_out_status;
        r_out_addr    <= n_out_addr;
        r_out_pref    <= n_out_pref;
        r_out_taken   <= n_out_taken;
        r_out_last    <= n_out_last;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_status     = r_out_status;
    assign o_entry_addr = r_out_addr;
    assign o_entry_pref = r_out_pref;
    assign o_pref_taken = r_out_taken;
    assign o_last       = r_out_last;

endmodule

[hw/rtl/router_preference_table.sv]
// channel  | direction | handshake                 | payload
// in       | input     | i_in_valid / o_in_ready   | i_op, i_gateway_addr, i_preference,
//          |           |                           | i_now_time
// out      | output    | o_out_valid / i_out_ready | o_kind, o_status, o_entry_addr,
//          |           |                           | o_entry_pref, o_pref_taken, o_last
// cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_wdata
//
// one item at a time; each table entry scanned takes a read-issue state, then an
// evaluate state on the registered read data of the entry memory
// add: the scan stops at a match or at the end of the table; advertise: every
// entry is scanned; both wait while the output is stalled
// reset clears the entry count and valid flags and sets config registers to defaults;
// table contents are left as they are and never read before being written
module router_preference_table #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [31:0]                   i_gateway_addr,
    input  logic signed [31:0]            i_preference,
    input  logic [31:0]                   i_now_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_entry_addr,
    output logic signed [31:0]            o_entry_pref,
    output logic                          o_pref_taken,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [rpt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import rpt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    t_cfg              r_cfg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    t_entry            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_entry            wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_timeout  <= DEST_TIMEOUT_RST;
            r_cfg.new_route_age <= NEW_ROUTE_AGE_RST;
            r_cfg.dead_age      <= DEAD_AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEST_TIMEOUT:  r_cfg.dest_timeout  <= i_cfg_wdata[15:0];
                CFG_NEW_ROUTE_AGE: r_cfg.new_route_age <= i_cfg_wdata[15:0];
                CFG_DEAD_AGE:      r_cfg.dead_age      <= i_cfg_wdata[23:0];
                default: begin
                end
            endcase
        end
    end

    rpt_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_gateway_addr (i_gateway_addr),
        .i_preference   (i_preference),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_entry_addr   (o_entry_addr),
        .o_entry_pref   (o_entry_pref),
        .o_pref_taken   (o_pref_taken),
        .o_last         (o_last),
        .o_rd_en        (rd_en),
        .o_rd_idx       (rd_idx),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_idx       (wr_idx),
        .o_wr_data      (wr_data)
    );

    rpt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data)
    );

endmodule

[tb/sv/router_preference_table_test.sv]
`timescale 1ns / 100ps

module router_preference_table_test;
    import rpt_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 30;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 30;

    typedef struct packed {
        logic               kind;
        t_status            status;
        logic [31:0]        addr;
        logic signed [31:0] pref;
        logic               taken;
        logic               last;
    } t_route_result;

    class route_table_scoreboard;
        logic [15:0]        dest_timeout;
        logic [15:0]        new_route_age;
        logic [23:0]        dead_age;
        logic [31:0]        gw_addr [TABLE_ENTRIES];
        logic signed [31:0] gw_pref [TABLE_ENTRIES];
        logic [31:0]        gw_seen [TABLE_ENTRIES];
        int unsigned        entry_count;
        t_route_result      route_results[$];
        int                 errors;

        function new();
            dest_timeout  = DEST_TIMEOUT_RST;
            new_route_age = NEW_ROUTE_AGE_RST;
            dead_age      = DEAD_AGE_RST;
            entry_count   = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEST_TIMEOUT:  dest_timeout  = data[15:0];
                CFG_NEW_ROUTE_AGE: new_route_age = data[15:0];
                CFG_DEAD_AGE:      dead_age      = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return route_results.size();
        endfunction

        function void apply_add(logic [31:0] addr, logic signed [31:0] pref, logic [31:0] now);
            int unsigned   i;
            int unsigned   slot;
            int unsigned   oldest;
            logic [31:0]   age;
            logic [31:0]   oldest_age;
            bit            found;
            bit            have_oldest;
            bit            taken;
            t_status       status;
            t_route_result res;
            slot        = 0;
            oldest      = 0;
            oldest_age  = '0;
            found       = 1'b0;
            have_oldest = 1'b0;
            // scan stops at a match, so oldest only covers entries before it
            for (i = 0; i < entry_count && !found; i++) begin
                age = now - gw_seen[i];
                if (gw_addr[i] == addr) begin
                    found = 1'b1;
                    slot  = i;
                end else if (!have_oldest || age > oldest_age) begin
                    have_oldest = 1'b1;
                    oldest      = i;
                    oldest_age  = age;
                end
            end
            if (found) begin
                age    = now - gw_seen[slot];
                status = ST_EXISTING;
                taken  = (pref >= gw_pref[slot]) || (age >= {16'd0, new_route_age});
            end else if (entry_count < TABLE_ENTRIES) begin
                slot = entry_count;
                entry_count++;
                status        = ST_APPENDED;
                gw_addr[slot] = addr;
                gw_pref[slot] = LOWEST_PREF;
                taken         = 1'b1;
            end else if (have_oldest && oldest_age > {16'd0, dest_timeout}) begin
                slot          = oldest;
                status        = ST_REPLACED;
                gw_addr[slot] = addr;
                gw_pref[slot] = LOWEST_PREF;
                taken         = 1'b1;
            end else begin
                res = '{KIND_STATUS, ST_DROPPED, addr, 32'sd0, 1'b0, 1'b1};
                route_results.push_back(res);
                return;
            end
            if (taken) begin
                gw_pref[slot] = pref;
                gw_seen[slot] = now;
            end
            res = '{KIND_STATUS, status, gw_addr[slot], gw_pref[slot], taken, 1'b1};
            route_results.push_back(res);
        endfunction

        function void apply_advertise(logic [31:0] now);
            int unsigned   i;
            int            emitted;
            logic [31:0]   age;
            t_route_result res;
            emitted = 0;
            for (i = 0; i < entry_count; i++) begin
                age = now - gw_seen[i];
                if (age <= {8'd0, dead_age}) begin
                    if (age > {16'd0, dest_timeout})
                        gw_pref[i] = LOWEST_PREF;
                    res = '{KIND_ENTRY, ST_EXISTING, gw_addr[i], gw_pref[i], 1'b0, 1'b0};
                    route_results.push_back(res);
                    emitted++;
                end
            end
            if (emitted > 0)
                route_results[route_results.size() - 1].last = 1'b1;
        endfunction

        function void note_request(logic op, logic [31:0] addr, logic signed [31:0] pref,
                                   logic [31:0] now);
            if (op == OP_ADD)
                apply_add(addr, pref, now);
            else
                apply_advertise(now);
        endfunction

        function void check_response(t_route_result got);
            t_route_result exp;
            if (route_results.size() == 0) begin
                $error("result with nothing expected: addr %08h pref %0d", got.addr, got.pref);
                errors++;
                return;
            end
            exp = route_results.pop_front();
            if (got.kind !== exp.kind) begin
                $error("kind expected %0d got %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status expected %0d got %0d", exp.status, got.status);
                errors++;
            end
            if (got.addr !== exp.addr) begin
                $error("entry_addr expected %08h got %08h", exp.addr, got.addr);
                errors++;
            end
            if (got.pref !== exp.pref) begin
                $error("entry_pref expected %0d got %0d", exp.pref, got.pref);
                errors++;
            end
            if (got.taken !== exp.taken) begin
                $error("pref_taken expected %0d got %0d", exp.taken, got.taken);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last expected %0d got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic                   i_op           = OP_ADD;
    logic [31:0]            i_gateway_addr = '0;
    logic signed [31:0]     i_preference   = '0;
    logic [31:0]            i_now_time     = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic                   o_kind;
    logic [1:0]             o_status;
    logic [31:0]            o_entry_addr;
    logic signed [31:0]     o_entry_pref;
    logic                   o_pref_taken;
    logic                   o_last;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx      = CFG_DEST_TIMEOUT;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata    = '0;

    route_table_scoreboard  sb;
    bit                     long_hold_req  = 1'b0;
    int                     quiet_cycles   = 0;
    logic [31:0]            clk_now;
    logic [31:0]            addr_pool [24];

    router_preference_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_gateway_addr(i_gateway_addr),
        .i_preference  (i_preference),
        .i_now_time    (i_now_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_entry_addr  (o_entry_addr),
        .o_entry_pref  (o_entry_pref),
        .o_pref_taken  (o_pref_taken),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // no handshake on either channel for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check on accept, then pick the ready for the next edge
    initial begin
        int          mode;
        int          mode_left;
        int          hold_left;
        int unsigned cyc;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_response('{o_kind, t_status'(o_status), o_entry_addr, o_entry_pref,
                                    o_pref_taken, o_last});
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= (cyc[1:0] != 2'd0);
                endcase
            end
        end
    end

    task automatic send_item(input logic op, input logic [31:0] addr,
                             input logic signed [31:0] pref, input logic [31:0] now);
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_gateway_addr <= addr;
        i_preference   <= pref;
        i_now_time     <= now;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_request(op, addr, pref, now);
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // an advertise with nothing live gives no result, so allow the block to finish
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] timeout_val,
                              input logic [CFG_DATA_W-1:0] new_age_val,
                              input logic [CFG_DATA_W-1:0] dead_val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DEST_TIMEOUT;
        i_cfg_wdata <= timeout_val;
        @(posedge i_clk);
        sb.set_reg(CFG_DEST_TIMEOUT, timeout_val);
        i_cfg_idx   <= CFG_NEW_ROUTE_AGE;
        i_cfg_wdata <= new_age_val;
        @(posedge i_clk);
        sb.set_reg(CFG_NEW_ROUTE_AGE, new_age_val);
        i_cfg_idx   <= CFG_DEAD_AGE;
        i_cfg_wdata <= dead_val;
        @(posedge i_clk);
        sb.set_reg(CFG_DEAD_AGE, dead_val);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_pref();
        case ($urandom_range(0, 5))
            0: return LOWEST_PREF;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic directed_items();
        int i;
        send_item(OP_ADVERTISE, 32'h1234_5678, 32'sd7, 32'd0);     // empty table
        send_item(OP_ADD, 32'h0000_0000, 32'sh7FFF_FFFF, 32'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, LOWEST_PREF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h0000_0000, -32'sd5, 32'd10);         // lower pref, young: kept
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'sd5, 32'd399);         // age wraps to 400
        send_item(OP_ADD, 32'h0000_0000, -32'sd1, 32'd320);        // lower pref but old enough
        send_item(OP_ADVERTISE, 32'h0, 32'sd0, 32'd950);           // first entry goes stale
        for (i = 0; i < 14; i++)
            send_item(OP_ADD, 32'h0A00_0001 + i, pick_pref(), 32'd1000);
        send_item(OP_ADD, 32'h0000_0000, 32'sh7FFF_FFFF, 32'd1000);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'sd5, 32'd1000);        // equal pref is taken
        send_item(OP_ADD, 32'hC0A8_0001, 32'sd3, 32'd1500);        // full, nothing stale
        send_item(OP_ADD, 32'hC0A8_0002, 32'sd4, 32'd1601);        // all tied, lowest evicted
        send_item(OP_ADVERTISE, 32'h0, 32'sd0, 32'd87401);         // all but one past dead age
        send_item(OP_ADVERTISE, 32'hFFFF_FFFF, 32'sd0, 32'd200000); // nothing live
    endtask

    task automatic random_items(input int count, input int unsigned step_max, input bit gaps);
        int          k;
        int          burst_left;
        logic        op;
        logic [31:0] addr;
        logic [31:0] now;
        burst_left = $urandom_range(1, 10);
        for (k = 0; k < count; k++) begin
            op   = ($urandom_range(0, 4) == 0) ? OP_ADVERTISE : OP_ADD;
            addr = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, 23)] : $urandom;
            case ($urandom_range(0, 19))
                0: now = $urandom;
                1: begin
                    clk_now = clk_now + $urandom_range(0, 200000);
                    now     = clk_now;
                end
                default: begin
                    clk_now = clk_now + $urandom_range(0, step_max);
                    now     = clk_now;
                end
            endcase
            send_item(op, addr, pick_pref(), now);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                if (gaps && $urandom_range(0, 1))
                    idle_input($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        int          ph;
        int unsigned step_max;
        logic [15:0] tmo;
        sb = new();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            addr_pool[i] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        wait_drained();

        clk_now = 32'd200000;
        for (ph = 0; ph < 5; ph++) begin
            step_max = 150;
            case (ph)
                1: begin
                    write_regs({8'($urandom), 16'd0}, {8'($urandom), 16'd0}, 24'd0);
                    step_max = 2;
                end
                2: begin
                    write_regs({8'($urandom), 16'hFFFF}, {8'($urandom), 16'hFFFF}, 24'hFF_FFFF);
                    step_max      = 30000;
                    long_hold_req = 1'b1;
                end
                3: begin
                    tmo = 16'($urandom_range(1, 200));
                    write_regs({8'd0, tmo}, 24'($urandom_range(0, 200)),
                               24'({8'd0, tmo} + $urandom_range(0, 400)));
                    step_max = 60;
                    clk_now  = 32'hFFFF_FFFF - 300;                  // ages wrap through zero
                end
                4: begin
                    tmo = 16'($urandom_range(0, 4000));
                    write_regs({8'($urandom), tmo}, 24'($urandom), 24'($urandom_range(0, 20000)));
                    step_max = tmo / 4 + 1;
                end
                default: ;
            endcase
            random_items(PHASE_ITEMS, step_max, ph != 4);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
